// File: src/drpke_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpke_pkg: shared constants and types
// Phase and header stage codes, DER tag values, result kinds.
// ----------------------------------------------------------------------------
package drpke_pkg;

    localparam int POS_BITS          = 16;
    localparam int MAX_MODULUS_BYTES = 512;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [4:0] P_START    = 5'd0;
    localparam logic [4:0] P_CERT     = 5'd1;
    localparam logic [4:0] P_TBS      = 5'd2;
    localparam logic [4:0] P_VERSION  = 5'd3;
    localparam logic [4:0] P_SERIAL   = 5'd4;
    localparam logic [4:0] P_SIGALG   = 5'd5;
    localparam logic [4:0] P_ISSUER   = 5'd6;
    localparam logic [4:0] P_VALIDITY = 5'd7;
    localparam logic [4:0] P_SUBJECT  = 5'd8;
    localparam logic [4:0] P_EXTRAS   = 5'd9;
    localparam logic [4:0] P_SPKI     = 5'd10;
    localparam logic [4:0] P_ALG      = 5'd11;
    localparam logic [4:0] P_BITS     = 5'd12;
    localparam logic [4:0] P_UNUSED   = 5'd13;
    localparam logic [4:0] P_INNER    = 5'd14;
    localparam logic [4:0] P_MOD      = 5'd15;
    localparam logic [4:0] P_EXP      = 5'd16;
    localparam logic [4:0] P_DONE     = 5'd17;

    localparam logic [2:0] S_TAG  = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_EXT  = 3'd2;
    localparam logic [2:0] S_SKIP = 3'd3;
    localparam logic [2:0] S_INT  = 3'd4;

    localparam logic [7:0] TAG_SEQ  = 8'h30;
    localparam logic [7:0] TAG_INT  = 8'h02;
    localparam logic [7:0] TAG_BITS = 8'h03;
    localparam logic [7:0] TAG_CTX0 = 8'hA0;
    localparam logic [7:0] TAG_CTX1 = 8'hA1;
    localparam logic [7:0] TAG_CTX2 = 8'hA2;
    localparam logic [7:0] TAG_CTX3 = 8'hA3;

    localparam logic [1:0] KIND_MOD = 2'd0;
    localparam logic [1:0] KIND_EXP = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    typedef logic [POS_BITS-1:0] pos_t;

    function automatic logic [4:0] phase_after_skip(input logic [4:0] ph);
        logic [4:0] r;
        unique case (ph)
            P_VERSION:  r = P_SERIAL;
            P_SERIAL:   r = P_SIGALG;
            P_SIGALG:   r = P_ISSUER;
            P_ISSUER:   r = P_VALIDITY;
            P_VALIDITY: r = P_SUBJECT;
            P_ALG:      r = P_BITS;
            default:    r = P_EXTRAS;
        endcase
        return r;
    endfunction

endpackage

// File: src/der_rsa_public_key_extractor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// der_rsa_public_key_extractor_top: RSA public key extractor for DER streams
// Walks an X.509 certificate or a bare SubjectPublicKeyInfo and emits the
// modulus and exponent bytes, leading zeros stripped, or one error beat.
// ----------------------------------------------------------------------------
// Usage: one DER byte per input beat, s_frame_end on the last byte. The block
// takes one beat per cycle while s_ready is high; each byte updates the
// registered parser state and produces at most one result beat into an output
// register, so it sustains one byte per clock whenever m_ready is high. The output
// register is a single stage; s_ready is high when it is empty or being
// drained this cycle. The format bit from cfg_wdata is sampled on the first
// byte of each object and must only be written while the block is idle. An
// error gives a single beat with kind 2 and key_last set; bytes after it are
// swallowed until s_frame_end, which always returns the parser to the start.
// ----------------------------------------------------------------------------
module der_rsa_public_key_extractor_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_frame_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_result_kind,
    output logic [7:0] m_result_byte,
    output logic       m_key_last
);

    typedef drpke_pkg::pos_t pos_t;
    localparam int PB = drpke_pkg::POS_BITS;
    // extended position math: 33 bits, well over the 16-bit position range
    typedef logic [32:0] ext_t;

    logic       fmt_reg;
    logic [4:0] phase_reg, phase_next;
    logic [2:0] stage_reg, stage_next;
    logic       cert_reg, cert_next;
    pos_t       pos_reg, pos_next;
    pos_t       cend_reg, cend_next;
    pos_t       tend_reg, tend_next;
    pos_t       kend_reg, kend_next;
    pos_t       bend_reg, bend_next;
    pos_t       skip_reg, skip_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0] lbl_reg, lbl_next;
    pos_t       ileft_reg, ileft_next;
    logic       strip_reg, strip_next;
    logic       fail_reg, fail_next;

    logic       mv_reg;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] ob_reg, ob_next;
    logic       last_reg, last_next;
    logic       emit;

    logic take;
    assign s_ready = !mv_reg || m_ready;
    assign take    = s_valid && s_ready;

    assign m_valid       = mv_reg;
    assign m_result_kind = kind_reg;
    assign m_result_byte = ob_reg;
    assign m_key_last    = last_reg;

    // per-byte parser step
    always_comb begin
        logic [7:0]  b;
        logic        ok;
        logic        inb;
        logic        hdr;
        logic [31:0] hlen;
        logic [4:0]  ph;
        ext_t        hend;
        logic        tag_ok;

        b          = s_data_byte;
        phase_next = phase_reg;
        stage_next = stage_reg;
        cert_next  = cert_reg;
        cend_next  = cend_reg;
        tend_next  = tend_reg;
        kend_next  = kend_reg;
        bend_next  = bend_reg;
        skip_next  = skip_reg;
        acc_next   = acc_reg;
        lbl_next   = lbl_reg;
        ileft_next = ileft_reg;
        strip_next = strip_reg;
        fail_next  = fail_reg;
        emit       = 1'b0;
        kind_next  = drpke_pkg::KIND_MOD;
        ob_next    = b;
        last_next  = 1'b0;
        ok         = 1'b1;
        hdr        = 1'b0;
        hlen       = '0;
        hend       = '0;
        tag_ok     = 1'b0;

        if (phase_reg == drpke_pkg::P_START) begin
            cert_next  = fmt_reg;
            phase_next = fmt_reg ? drpke_pkg::P_CERT : drpke_pkg::P_SPKI;
            stage_next = drpke_pkg::S_TAG;
        end

        ph = phase_next;
        // bounds rule for key headers; phase may move inside tag handling
        inb = 1'b1;

        if (!fail_reg && phase_next != drpke_pkg::P_DONE) begin
            if (ph == drpke_pkg::P_UNUSED) begin
                ok = pos_reg < kend_reg;
                phase_next = drpke_pkg::P_INNER;
                stage_next = drpke_pkg::S_TAG;
            end else begin
                case (stage_next)
                    drpke_pkg::S_TAG: begin
                        if (ph == drpke_pkg::P_VERSION) begin
                            if (pos_reg < tend_reg && b == drpke_pkg::TAG_CTX0)
                                tag_ok = 1'b1;
                            else
                                ph = drpke_pkg::P_SERIAL;
                        end
                        if (!tag_ok && ph == drpke_pkg::P_EXTRAS) begin
                            if (pos_reg < tend_reg && (b == drpke_pkg::TAG_CTX1 ||
                                b == drpke_pkg::TAG_CTX2 || b == drpke_pkg::TAG_CTX3))
                                tag_ok = 1'b1;
                            else
                                ph = drpke_pkg::P_SPKI;
                        end
                        if (tag_ok) begin
                            ok = 1'b1;
                        end else if (phase_next == drpke_pkg::P_EXTRAS &&
                                     pos_reg >= tend_reg) begin
                            ok = 1'b0;
                        end else begin
                            if (ph == drpke_pkg::P_SPKI || ph == drpke_pkg::P_ALG ||
                                ph == drpke_pkg::P_BITS || ph == drpke_pkg::P_MOD ||
                                ph == drpke_pkg::P_EXP)
                                inb = !cert_next || (pos_reg < tend_reg);
                            else if (ph == drpke_pkg::P_INNER)
                                inb = pos_reg < bend_reg;
                            case (ph)
                                drpke_pkg::P_CERT: ok = b == drpke_pkg::TAG_SEQ;
                                drpke_pkg::P_TBS:
                                    ok = pos_reg < cend_reg && b == drpke_pkg::TAG_SEQ;
                                drpke_pkg::P_SERIAL:
                                    ok = pos_reg < tend_reg && b == drpke_pkg::TAG_INT;
                                drpke_pkg::P_SIGALG, drpke_pkg::P_ISSUER,
                                drpke_pkg::P_VALIDITY, drpke_pkg::P_SUBJECT:
                                    ok = pos_reg < tend_reg && b == drpke_pkg::TAG_SEQ;
                                drpke_pkg::P_SPKI, drpke_pkg::P_ALG, drpke_pkg::P_INNER:
                                    ok = b == drpke_pkg::TAG_SEQ;
                                drpke_pkg::P_BITS:
                                    ok = pos_reg < kend_reg && b == drpke_pkg::TAG_BITS;
                                drpke_pkg::P_MOD, drpke_pkg::P_EXP:
                                    ok = b == drpke_pkg::TAG_INT;
                                default: ok = 1'b0;
                            endcase
                            ok = ok && inb;
                        end
                        phase_next = ph;
                        stage_next = drpke_pkg::S_LEN;
                    end
                    drpke_pkg::S_LEN, drpke_pkg::S_EXT: begin
                        if (ph == drpke_pkg::P_SPKI || ph == drpke_pkg::P_ALG ||
                            ph == drpke_pkg::P_BITS || ph == drpke_pkg::P_MOD ||
                            ph == drpke_pkg::P_EXP)
                            inb = !cert_next || (pos_reg < tend_reg);
                        else if (ph == drpke_pkg::P_INNER)
                            inb = pos_reg < bend_reg;
                        if (!inb) begin
                            ok = 1'b0;
                        end else if (stage_next == drpke_pkg::S_LEN) begin
                            if (!b[7]) begin
                                hdr  = 1'b1;
                                hlen = {24'd0, b};
                            end else begin
                                lbl_next = b[2:0];
                                acc_next = '0;
                                if (b[6:0] > 7'd4) ok = 1'b0;
                                else if (b[6:0] == 7'd0) hdr = 1'b1;
                                else stage_next = drpke_pkg::S_EXT;
                            end
                        end else begin
                            acc_next = {acc_reg[23:0], b};
                            lbl_next = lbl_reg - 3'd1;
                            if (lbl_next == 3'd0) begin
                                hdr  = 1'b1;
                                hlen = acc_next;
                            end
                        end
                    end
                    drpke_pkg::S_SKIP: begin
                        skip_next = skip_reg - pos_t'(1);
                        if (skip_next == '0) begin
                            phase_next = drpke_pkg::phase_after_skip(ph);
                            stage_next = drpke_pkg::S_TAG;
                        end
                    end
                    default: begin
                        if (strip_reg && b == 8'd0 && ileft_reg > pos_t'(1)) begin
                            ileft_next = ileft_reg - pos_t'(1);
                        end else if (strip_reg && 32'(ileft_reg) >
                                     32'(drpke_pkg::MAX_MODULUS_BYTES)) begin
                            ok = 1'b0;
                        end else begin
                            strip_next = 1'b0;
                            emit       = 1'b1;
                            kind_next  = (ph == drpke_pkg::P_MOD) ? drpke_pkg::KIND_MOD
                                                                  : drpke_pkg::KIND_EXP;
                            ileft_next = ileft_reg - pos_t'(1);
                            if (ileft_next == '0) begin
                                if (ph == drpke_pkg::P_MOD) begin
                                    phase_next = drpke_pkg::P_EXP;
                                    stage_next = drpke_pkg::S_TAG;
                                end else begin
                                    phase_next = drpke_pkg::P_DONE;
                                    last_next  = 1'b1;
                                end
                            end
                        end
                    end
                endcase

                if (hdr) begin
                    hend = ext_t'(pos_reg) + 33'd1 + ext_t'(hlen);
                    stage_next = drpke_pkg::S_TAG;
                    if (hend > ext_t'(drpke_pkg::POS_MAX)) begin
                        ok = 1'b0;
                    end else begin
                        case (ph)
                            drpke_pkg::P_CERT: begin
                                cend_next  = hend[PB-1:0];
                                phase_next = drpke_pkg::P_TBS;
                            end
                            drpke_pkg::P_TBS: begin
                                tend_next  = hend[PB-1:0];
                                phase_next = drpke_pkg::P_VERSION;
                            end
                            drpke_pkg::P_SPKI: begin
                                if (hlen < 32'd2) ok = 1'b0;
                                kend_next  = hend[PB-1:0];
                                phase_next = drpke_pkg::P_ALG;
                            end
                            drpke_pkg::P_BITS: begin
                                bend_next  = hend[PB-1:0];
                                phase_next = drpke_pkg::P_UNUSED;
                            end
                            drpke_pkg::P_INNER: phase_next = drpke_pkg::P_MOD;
                            drpke_pkg::P_MOD, drpke_pkg::P_EXP: begin
                                if (hlen == 32'd0) ok = 1'b0;
                                ileft_next = hlen[PB-1:0];
                                strip_next = 1'b1;
                                stage_next = drpke_pkg::S_INT;
                            end
                            default: begin
                                if (hlen == 32'd0) begin
                                    phase_next = drpke_pkg::phase_after_skip(ph);
                                end else begin
                                    skip_next  = hlen[PB-1:0];
                                    stage_next = drpke_pkg::S_SKIP;
                                end
                            end
                        endcase
                    end
                end
            end
            if (!ok) begin
                fail_next = 1'b1;
                emit      = 1'b1;
                kind_next = drpke_pkg::KIND_ERR;
            end
        end

        // early frame end
        if (s_frame_end && kind_next != drpke_pkg::KIND_ERR && !fail_next &&
            phase_next != drpke_pkg::P_DONE) begin
            fail_next = 1'b1;
            emit      = 1'b1;
            kind_next = drpke_pkg::KIND_ERR;
        end
        if (emit && kind_next == drpke_pkg::KIND_ERR) begin
            ob_next   = 8'd0;
            last_next = 1'b1;
        end

        pos_next = (pos_reg < drpke_pkg::POS_MAX) ? pos_reg + pos_t'(1) : pos_reg;

        if (s_frame_end) begin
            phase_next = drpke_pkg::P_START;
            stage_next = drpke_pkg::S_TAG;
            cert_next  = 1'b0;
            pos_next   = '0;
            cend_next  = '0;
            tend_next  = '0;
            kend_next  = '0;
            bend_next  = '0;
            skip_next  = '0;
            acc_next   = '0;
            lbl_next   = '0;
            ileft_next = '0;
            strip_next = 1'b0;
            fail_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg   <= 1'b0;
            phase_reg <= drpke_pkg::P_START;
            stage_reg <= drpke_pkg::S_TAG;
            cert_reg  <= 1'b0;
            pos_reg   <= '0;
            cend_reg  <= '0;
            tend_reg  <= '0;
            kend_reg  <= '0;
            bend_reg  <= '0;
            skip_reg  <= '0;
            acc_reg   <= '0;
            lbl_reg   <= '0;
            ileft_reg <= '0;
            strip_reg <= 1'b0;
            fail_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_we) fmt_reg <= cfg_wdata;
            if (take) begin
                phase_reg <= phase_next;
                stage_reg <= stage_next;
                cert_reg  <= cert_next;
                pos_reg   <= pos_next;
                cend_reg  <= cend_next;
                tend_reg  <= tend_next;
                kend_reg  <= kend_next;
                bend_reg  <= bend_next;
                skip_reg  <= skip_next;
                acc_reg   <= acc_next;
                lbl_reg   <= lbl_next;
                ileft_reg <= ileft_next;
                strip_reg <= strip_next;
                fail_reg  <= fail_next;
            end
            if (take) mv_reg <= emit;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (take && emit) begin
            kind_reg <= kind_next;
            ob_reg   <= ob_next;
            last_reg <= last_next;
        end
    end

endmodule

// File: src/drpke_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpke_checker: port-level checks
// Watches the top level's ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module drpke_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_result_kind,
    input logic [7:0] m_result_byte,
    input logic       m_key_last
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_byte) &&
        $stable(m_result_kind))
        else $error("result beat changed while stalled");

    // error beats carry zero and key_last
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == drpke_pkg::KIND_ERR |->
        m_key_last && m_result_byte == 8'd0)
        else $error("malformed error beat");

    // modulus bytes never carry key_last
    a_modlast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == drpke_pkg::KIND_MOD |-> !m_key_last)
        else $error("key_last on modulus byte");

    // never blocks input while the output side is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // no kind code past error
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result_kind != 2'd3)
        else $error("bad result kind");

endmodule

bind der_rsa_public_key_extractor_top drpke_checker u_drpke_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_result_byte (m_result_byte),
    .m_key_last    (m_key_last)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for der_rsa_public_key_extractor_top
// Feeds DER objects (bare SubjectPublicKeyInfo and full certificates, well
// formed, broken and noise) one beat per byte. A cycle-free parser model
// predicts every modulus, exponent and error beat, and each output beat is
// compared field by field against the oldest prediction. Both sides stall
// in random bursts except in the final stretch of the run.
// ----------------------------------------------------------------------------
module tb;

    typedef logic [7:0] bytes_t[$];

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } key_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_frame_end;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_result_kind;
    logic [7:0] m_result_byte;
    logic       m_key_last;

    der_rsa_public_key_extractor_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_end   (s_frame_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_result_byte (m_result_byte),
        .m_key_last    (m_key_last)
    );

    // Beats the parser model says are still owed by the block.
    key_beat_t key_beats_due[$];
    int        err_count;
    int        bytes_sent;
    bit        calm;          // no idling on either side when set

    // ------------------------------------------------------------------
    // Parser model state (one object at a time, cleared on frame end)
    // ------------------------------------------------------------------
    bit               fmt_cert;       // register copy
    bit               obj_is_cert;    // format latched on first byte
    logic [4:0]       walk_phase;
    logic [2:0]       hdr_stage;
    longint unsigned  pos;
    longint unsigned  cert_limit;
    longint unsigned  tbs_limit;
    longint unsigned  keyseq_limit;
    longint unsigned  bits_limit;
    longint unsigned  skip_left;
    longint unsigned  int_left;
    logic [31:0]      len_acc;
    int               len_left;
    bit               strip_on;
    bit               obj_failed;

    function automatic void clear_object();
        walk_phase   = drpke_pkg::P_START;
        hdr_stage    = drpke_pkg::S_TAG;
        obj_is_cert  = 0;
        pos          = 0;
        cert_limit   = 0;
        tbs_limit    = 0;
        keyseq_limit = 0;
        bits_limit   = 0;
        skip_left    = 0;
        int_left     = 0;
        len_acc      = 0;
        len_left     = 0;
        strip_on     = 0;
        obj_failed   = 0;
    endfunction

    function automatic logic [4:0] next_after_skip(input logic [4:0] ph);
        case (ph)
            drpke_pkg::P_VERSION:  return drpke_pkg::P_SERIAL;
            drpke_pkg::P_SERIAL:   return drpke_pkg::P_SIGALG;
            drpke_pkg::P_SIGALG:   return drpke_pkg::P_ISSUER;
            drpke_pkg::P_ISSUER:   return drpke_pkg::P_VALIDITY;
            drpke_pkg::P_VALIDITY: return drpke_pkg::P_SUBJECT;
            drpke_pkg::P_ALG:      return drpke_pkg::P_BITS;
            default:               return drpke_pkg::P_EXTRAS;
        endcase
    endfunction

    // key headers must sit inside the TBS (cert) or the BIT STRING
    function automatic bit header_fits();
        case (walk_phase)
            drpke_pkg::P_SPKI, drpke_pkg::P_ALG, drpke_pkg::P_BITS,
            drpke_pkg::P_MOD, drpke_pkg::P_EXP:
                return obj_is_cert ? (pos < tbs_limit) : 1'b1;
            drpke_pkg::P_INNER: return pos < bits_limit;
            default: return 1'b1;
        endcase
    endfunction

    function automatic bit tag_accepted(input logic [7:0] b);
        if (walk_phase == drpke_pkg::P_VERSION) begin
            if (pos < tbs_limit && b == drpke_pkg::TAG_CTX0) return 1'b1;
            walk_phase = drpke_pkg::P_SERIAL;
        end
        if (walk_phase == drpke_pkg::P_EXTRAS) begin
            if (pos < tbs_limit && (b == drpke_pkg::TAG_CTX1 || b == drpke_pkg::TAG_CTX2 ||
                                    b == drpke_pkg::TAG_CTX3))
                return 1'b1;
            if (pos >= tbs_limit) return 1'b0;
            walk_phase = drpke_pkg::P_SPKI;
        end
        if (!header_fits()) return 1'b0;
        case (walk_phase)
            drpke_pkg::P_CERT: return b == drpke_pkg::TAG_SEQ;
            drpke_pkg::P_TBS: return pos < cert_limit && b == drpke_pkg::TAG_SEQ;
            drpke_pkg::P_SERIAL: return pos < tbs_limit && b == drpke_pkg::TAG_INT;
            drpke_pkg::P_SIGALG, drpke_pkg::P_ISSUER, drpke_pkg::P_VALIDITY,
            drpke_pkg::P_SUBJECT:
                return pos < tbs_limit && b == drpke_pkg::TAG_SEQ;
            drpke_pkg::P_SPKI, drpke_pkg::P_ALG, drpke_pkg::P_INNER:
                return b == drpke_pkg::TAG_SEQ;
            drpke_pkg::P_BITS: return pos < keyseq_limit && b == drpke_pkg::TAG_BITS;
            drpke_pkg::P_MOD, drpke_pkg::P_EXP: return b == drpke_pkg::TAG_INT;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit header_done(input longint unsigned len);
        longint unsigned stop;
        stop = pos + 1 + len;
        if (stop > longint'(drpke_pkg::POS_MAX)) return 1'b0;
        hdr_stage = drpke_pkg::S_TAG;
        case (walk_phase)
            drpke_pkg::P_CERT: begin
                cert_limit = stop;
                walk_phase = drpke_pkg::P_TBS;
            end
            drpke_pkg::P_TBS: begin
                tbs_limit  = stop;
                walk_phase = drpke_pkg::P_VERSION;
            end
            drpke_pkg::P_SPKI: begin
                if (len < 2) return 1'b0;
                keyseq_limit = stop;
                walk_phase   = drpke_pkg::P_ALG;
            end
            drpke_pkg::P_BITS: begin
                bits_limit = stop;
                walk_phase = drpke_pkg::P_UNUSED;
            end
            drpke_pkg::P_INNER: walk_phase = drpke_pkg::P_MOD;
            drpke_pkg::P_MOD, drpke_pkg::P_EXP: begin
                if (len == 0) return 1'b0;
                int_left  = len;
                strip_on  = 1;
                hdr_stage = drpke_pkg::S_INT;
            end
            default: begin
                if (len == 0) begin
                    walk_phase = next_after_skip(walk_phase);
                end else begin
                    skip_left = len;
                    hdr_stage = drpke_pkg::S_SKIP;
                end
            end
        endcase
        return 1'b1;
    endfunction

    // returns 0 on a parse failure; kind stays -1 when no beat is due
    function automatic bit parse_byte(input logic [7:0] b, inout int kind,
                                      inout logic [7:0] ob, inout bit last);
        if (walk_phase == drpke_pkg::P_UNUSED) begin
            if (pos >= keyseq_limit) return 1'b0;
            walk_phase = drpke_pkg::P_INNER;
            hdr_stage  = drpke_pkg::S_TAG;
            return 1'b1;
        end
        case (hdr_stage)
            drpke_pkg::S_TAG: begin
                if (!tag_accepted(b)) return 1'b0;
                hdr_stage = drpke_pkg::S_LEN;
                return 1'b1;
            end
            drpke_pkg::S_LEN: begin
                if (!header_fits()) return 1'b0;
                if (!b[7]) return header_done(b);
                len_left = b[6:0];
                if (len_left > 4) return 1'b0;
                len_acc = 0;
                if (len_left == 0) return header_done(0);
                hdr_stage = drpke_pkg::S_EXT;
                return 1'b1;
            end
            drpke_pkg::S_EXT: begin
                if (!header_fits()) return 1'b0;
                len_acc  = {len_acc[23:0], b};
                len_left = len_left - 1;
                if (len_left == 0) return header_done(len_acc);
                return 1'b1;
            end
            drpke_pkg::S_SKIP: begin
                skip_left = skip_left - 1;
                if (skip_left == 0) begin
                    walk_phase = next_after_skip(walk_phase);
                    hdr_stage  = drpke_pkg::S_TAG;
                end
                return 1'b1;
            end
            default: begin
                if (strip_on && b == 8'h00 && int_left > 1) begin
                    int_left = int_left - 1;
                    return 1'b1;
                end
                if (strip_on) begin
                    strip_on = 0;
                    if (int_left > drpke_pkg::MAX_MODULUS_BYTES) return 1'b0;
                end
                kind     = (walk_phase == drpke_pkg::P_MOD) ? drpke_pkg::KIND_MOD
                                                           : drpke_pkg::KIND_EXP;
                ob       = b;
                int_left = int_left - 1;
                if (int_left == 0) begin
                    if (walk_phase == drpke_pkg::P_MOD) begin
                        walk_phase = drpke_pkg::P_EXP;
                        hdr_stage  = drpke_pkg::S_TAG;
                    end else begin
                        walk_phase = drpke_pkg::P_DONE;
                        last       = 1;
                    end
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void predict_key_beat(input logic [7:0] b, input logic fe);
        int         kind;
        logic [7:0] ob;
        bit         last;
        key_beat_t  kb;
        kind = -1;
        ob   = 0;
        last = 0;
        if (walk_phase == drpke_pkg::P_START) begin
            obj_is_cert = fmt_cert;
            walk_phase  = obj_is_cert ? drpke_pkg::P_CERT : drpke_pkg::P_SPKI;
            hdr_stage   = drpke_pkg::S_TAG;
        end
        if (!obj_failed && walk_phase != drpke_pkg::P_DONE) begin
            if (!parse_byte(b, kind, ob, last)) begin
                obj_failed = 1;
                kind       = drpke_pkg::KIND_ERR;
            end
        end
        // early end outranks a modulus byte on the same beat
        if (fe && kind != drpke_pkg::KIND_ERR && !obj_failed &&
            walk_phase != drpke_pkg::P_DONE) begin
            obj_failed = 1;
            kind       = drpke_pkg::KIND_ERR;
        end
        if (kind == drpke_pkg::KIND_ERR) begin
            ob   = 0;
            last = 1;
        end
        if (kind >= 0) begin
            kb.kind = kind[1:0];
            kb.data = ob;
            kb.last = last;
            key_beats_due.push_back(kb);
        end
        if (pos < longint'(drpke_pkg::POS_MAX)) pos = pos + 1;
        if (fe) clear_object();
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit, sink side
    // ------------------------------------------------------------------
    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Sink stalls in random bursts, none once calm is set.
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_ready = 0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end
            m_ready = 1;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    // Result checker: every accepted output beat against the oldest prediction.
    always @(posedge aclk) begin
        key_beat_t kb;
        if (aresetn && m_valid && m_ready) begin
            if (key_beats_due.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kind=%0d byte=%02h last=%0d",
                                          m_result_kind, m_result_byte, m_key_last));
            end else begin
                kb = key_beats_due.pop_front();
                if (m_result_kind !== kb.kind || m_result_byte !== kb.data ||
                    m_key_last !== kb.last)
                    report_mismatch($sformatf("got kind=%0d byte=%02h last=%0d, want %0d %02h %0d",
                                              m_result_kind, m_result_byte, m_key_last,
                                              kb.kind, kb.data, kb.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic fe);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid = 0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid     = 1;
        s_data_byte = b;
        s_frame_end = fe;
        do @(posedge aclk); while (!s_ready);
        predict_key_beat(b, fe);
        bytes_sent++;
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic send_object(input bytes_t q);
        foreach (q[i]) send_beat(q[i], i == q.size() - 1);
    endtask

    // hold the source until every owed beat is out, then let the pipe settle
    task automatic drain_keys();
        while (key_beats_due.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic set_format(input bit v);
        drain_keys();
        cfg_we    = 1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we   = 0;
        fmt_cert = v;
    endtask

    // ------------------------------------------------------------------
    // DER builders
    // ------------------------------------------------------------------
    function automatic bytes_t der_len(input int n);
        if (n < 128) return '{n[7:0]};
        if (n < 256) return '{8'h81, n[7:0]};
        return '{8'h82, n[15:8], n[7:0]};
    endfunction

    function automatic bytes_t tlv(input logic [7:0] tag, input bytes_t body);
        bytes_t r;
        r = {tag, der_len(body.size()), body};
        return r;
    endfunction

    function automatic bytes_t rand_fill(input int n);
        bytes_t r;
        repeat (n) r.push_back(8'($urandom_range(0, 255)));
        return r;
    endfunction

    // INTEGER with nz significant bytes (first one nonzero) after zeros pad
    function automatic bytes_t der_int(input int zeros, input int nz);
        bytes_t c;
        repeat (zeros) c.push_back(8'h00);
        if (nz > 0) c.push_back(8'($urandom_range(1, 255)));
        if (nz > 1) c = {c, rand_fill(nz - 1)};
        return tlv(drpke_pkg::TAG_INT, c);
    endfunction

    function automatic bytes_t spki_from(input bytes_t modq, input bytes_t expq);
        bytes_t alg, inner, bits;
        alg   = tlv(drpke_pkg::TAG_SEQ, '{8'h06, 8'h03, 8'h2A, 8'h86, 8'h48, 8'h05, 8'h00});
        inner = tlv(drpke_pkg::TAG_SEQ, {modq, expq});
        bits  = tlv(drpke_pkg::TAG_BITS, {8'h00, inner});
        return tlv(drpke_pkg::TAG_SEQ, {alg, bits});
    endfunction

    function automatic bytes_t rand_spki();
        return spki_from(der_int($urandom_range(0, 3), $urandom_range(1, 24)),
                         der_int($urandom_range(0, 1), $urandom_range(1, 4)));
    endfunction

    function automatic bytes_t cert_from(input bytes_t spki, input bit with_ver,
                                         input int extras);
        bytes_t tbs, c;
        if (with_ver)
            tbs = tlv(drpke_pkg::TAG_CTX0, '{drpke_pkg::TAG_INT, 8'h01, 8'h02});
        tbs = {tbs, tlv(drpke_pkg::TAG_INT, rand_fill($urandom_range(1, 6)))};
        tbs = {tbs, tlv(drpke_pkg::TAG_SEQ, rand_fill($urandom_range(0, 4)))};
        tbs = {tbs, tlv(drpke_pkg::TAG_SEQ, rand_fill($urandom_range(0, 8)))};
        tbs = {tbs, tlv(drpke_pkg::TAG_SEQ, rand_fill($urandom_range(0, 6)))};
        tbs = {tbs, tlv(drpke_pkg::TAG_SEQ, rand_fill($urandom_range(0, 8)))};
        for (int i = 0; i < extras; i++)
            tbs = {tbs, tlv(8'(drpke_pkg::TAG_CTX1 + $urandom_range(0, 2)),
                            rand_fill($urandom_range(0, 3)))};
        tbs = {tbs, spki, tlv(drpke_pkg::TAG_CTX3, rand_fill($urandom_range(0, 4)))};
        c = {tlv(drpke_pkg::TAG_SEQ, tbs), tlv(drpke_pkg::TAG_SEQ, rand_fill(3)),
             tlv(drpke_pkg::TAG_BITS, rand_fill(4))};
        return tlv(drpke_pkg::TAG_SEQ, c);
    endfunction

    // damage a well formed object: flip a byte, cut it short, or both
    function automatic bytes_t break_object(input bytes_t q);
        int cut;
        if ($urandom_range(0, 1))
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
            cut = $urandom_range(1, q.size());
            while (q.size() > cut) void'(q.pop_back());
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_spki_extremes();
        // single zero modulus kept, all-ones exponent, trailing junk ignored
        send_object(spki_from('{drpke_pkg::TAG_INT, 8'h01, 8'h00},
                              '{drpke_pkg::TAG_INT, 8'h01, 8'hFF}));
        send_object({spki_from(der_int(2, 3), der_int(0, 3)), 8'hFF, 8'h00});
    endtask

    task automatic test_header_errors();
        send_object('{8'h31, 8'h00});                                   // wrong outer tag
        send_object('{drpke_pkg::TAG_SEQ, 8'h85, 8'h01});               // five length bytes
        send_object('{drpke_pkg::TAG_SEQ, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF}); // past range
        send_object('{drpke_pkg::TAG_SEQ, 8'h82, 8'hFF, 8'hFF});        // just past range
        send_object('{drpke_pkg::TAG_SEQ, 8'h01, 8'h00});               // key seq too short
        send_object('{drpke_pkg::TAG_SEQ, 8'h80, 8'h7F});               // zero-length form
        send_object('{drpke_pkg::TAG_SEQ, 8'h05, drpke_pkg::TAG_INT, 8'h01, 8'h05,
                      8'h00, 8'h00});                                   // bare INTEGER
        send_object(spki_from('{drpke_pkg::TAG_INT, 8'h00}, der_int(0, 1))); // empty modulus
        send_object(spki_from(der_int(0, 4), '{drpke_pkg::TAG_INT, 8'h00})); // empty exponent
        send_object('{8'h80});                                          // bad tag as the only byte
    endtask

    task automatic test_early_end();
        bytes_t q;
        q = spki_from(der_int(0, 3), der_int(0, 2));
        void'(q.pop_back());                                        // ends on an exponent byte
        send_object(q);
        q = spki_from(der_int(0, 3), der_int(0, 1));
        q = q[0:q.size() - 4];                                      // last modulus byte
        send_object(q);
    endtask

    task automatic test_oversize();
        bytes_t q;
        // modulus content starts at offset 26 in these objects; each is cut two or
        // three bytes in, since the size check sits on the first kept byte.
        // 513 significant bytes: error on the first kept byte.
        q = spki_from(der_int(0, drpke_pkg::MAX_MODULUS_BYTES + 1), der_int(0, 1));
        q = q[0:27];
        send_object(q);
        // 512 after a stripped zero: one modulus byte, then the early-end error
        q = spki_from(der_int(1, drpke_pkg::MAX_MODULUS_BYTES), der_int(0, 1));
        q = q[0:28];
        send_object(q);
    endtask

    task automatic test_certificate();
        set_format(1);
        send_object(cert_from(rand_spki(), 1, 0));
        send_object(cert_from(rand_spki(), 0, 3));
        // version plus one extra item ahead of the key
        send_object(cert_from(rand_spki(), 1, 1));
        send_object(rand_spki());                                   // bare in cert mode
        set_format(0);
    endtask

    task automatic test_random_objects();
        int pick;
        while (bytes_sent < 750) begin
            if (bytes_sent > 650) calm = 1;
            if ($urandom_range(0, 5) == 0) set_format($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                if (fmt_cert) send_object(cert_from(rand_spki(), $urandom_range(0, 1),
                                                    $urandom_range(0, 2)));
                else send_object(rand_spki());
            end else if (pick < 9) begin
                send_object(break_object(fmt_cert ?
                    cert_from(rand_spki(), $urandom_range(0, 1), $urandom_range(0, 2)) :
                    rand_spki()));
            end else begin
                send_object(rand_fill($urandom_range(1, 12)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        err_count   = 0;
        bytes_sent  = 0;
        calm        = 0;
        fmt_cert    = 0;
        aresetn     = 0;
        cfg_we      = 0;
        cfg_wdata   = 0;
        s_valid     = 0;
        s_data_byte = 0;
        s_frame_end = 0;
        clear_object();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        test_spki_extremes();       // reset format is bare key
        test_header_errors();
        test_early_end();
        set_format(0);
        test_oversize();
        test_certificate();
        test_random_objects();

        drain_keys();
        repeat (20) @(negedge aclk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
src/drpke_pkg.sv
src/der_rsa_public_key_extractor_top.sv
src/drpke_checker.sv
tb/tb.sv
